FILE: src/lz4d_pkg.sv
// Package with shared constants and types of the LZ4 block decoder.
package lz4d_pkg;

    localparam int WindowBytes = 65536;
    localparam int AddrBits    = $clog2(WindowBytes);
    localparam int CountBits   = 24;

    // Parser phases.
    localparam logic [2:0] PH_TOKEN     = 3'd0;
    localparam logic [2:0] PH_LIT_EXT   = 3'd1;
    localparam logic [2:0] PH_LITERALS  = 3'd2;
    localparam logic [2:0] PH_OFF_LO    = 3'd3;
    localparam logic [2:0] PH_OFF_HI    = 3'd4;
    localparam logic [2:0] PH_MATCH_EXT = 3'd5;
    localparam logic [2:0] PH_COPY      = 3'd6;

    // Result status codes.
    localparam logic [2:0] ST_DATA     = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_TRUNC    = 3'd2;
    localparam logic [2:0] ST_OFFSET   = 3'd3;
    localparam logic [2:0] ST_CAPACITY = 3'd4;
    localparam logic [2:0] ST_SEQ      = 3'd5;

    localparam logic KIND_SOURCE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // One result item, before the history read data is merged in.
    typedef struct packed {
        logic                 from_mem;
        logic [7:0]           out_byte;
        logic [2:0]           status;
        logic [CountBits-1:0] total_length;
        logic                 copy_pending;
    } t_result;

endpackage

FILE: src/lz4d_history.sv
// History memory of the decoder: one write port, one registered read port.
module lz4d_history
    import lz4d_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AddrBits-1:0] i_waddr,
    input  logic [7:0]          i_wdata,
    input  logic                i_re,
    input  logic [AddrBits-1:0] i_raddr,
    output logic [7:0]          o_rdata
);

    logic [7:0] r_mem [WindowBytes];
    logic [7:0] r_rdata;

    // Synchronous write and read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/lz4_block_decoder_unit.sv
// Top level of the LZ4 block decoder.
// Compressed bytes and copy ticks enter on the s_axis channel. tdata carries
// source_byte, tuser the kind (0 source byte, 1 copy tick), and tlast marks the
// last source byte of a block. Each item gives zero or one result item on
// m_axis: tdata holds out_byte, total_length and copy_pending, tuser the status.
// The whole out_capacity limit is written through i_cfg_we/i_cfg_wdata. The
// user must do so only while no item is in flight; the block does not enforce it.
// Throughput is one item per cycle, copy ticks included, while the receiver does
// not stall. An item is parsed and its history read issued as it is accepted;
// stage 1 registers it, and the read data is merged in as it moves on into the
// output register.
// A match byte whose source byte still sits in the pipeline stage is taken from
// there, so matches with a period of one byte stream without a stall.
// Reset clears the parser, the counters and both valid flags, and sets the limit
// to 65536. The history memory is not cleared, since every read lands on a byte
// that was written earlier in the same block.
// When the receiver stalls, the output register holds its item and the pipeline
// stage takes one more result item, items without one still being accepted. After
// that, s_axis_tready stays low until m_axis_tready returns.
module lz4_block_decoder_unit
    import lz4d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
    input  logic        s_axis_tuser,   // [0] kind
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [31:8] total_length,
                                        // [32] copy_pending, rest zero
    output logic [2:0]  m_axis_tuser    // [2:0] status
);

    localparam logic [CountBits:0] CountMax = {1'b0, {CountBits{1'b1}}};

    logic [23:0]          r_cap;
    logic [2:0]           r_phase;
    logic [3:0]           r_mnib;
    logic [CountBits-1:0] r_lit;
    logic [CountBits-1:0] r_mlen;
    logic [15:0]          r_off;
    logic [CountBits-1:0] r_prod;
    logic                 r_skip;

    logic [2:0]           n_phase;
    logic [3:0]           n_mnib;
    logic [CountBits-1:0] n_lit;
    logic [CountBits-1:0] n_mlen;
    logic [15:0]          n_off;
    logic [CountBits-1:0] n_prod;
    logic                 n_skip;

    // Stage 1 holds an item whose data may come from the memory.
    logic                r_s1_vld;
    t_result             r_s1;
    logic                r_s1_fwd;
    logic [7:0]          r_s1_fwd_byte;
    logic [AddrBits-1:0] r_s1_waddr;
    t_result             n_res;
    logic                n_emit;

    // Output register.
    logic       r_o_vld;
    t_result    r_o;
    t_result    s1_out;

    logic [7:0]          mem_rdata;
    logic [7:0]          s1_byte;
    logic                s1_we;
    logic                re;
    logic [AddrBits-1:0] raddr;
    logic [15:0]         rd_dist;
    logic                fwd;

    logic       s1_free;
    logic       o_take;
    logic       acc;
    logic       mstart;

    logic [CountBits:0] lim;
    logic [CountBits:0] lit_sum, mlen_sum, mlen_len, len_less;
    logic [CountBits:0] start_len;
    logic [CountBits:0] cap_need;
    logic [16:0]        off_full;

    assign o_take        = !r_o_vld || m_axis_tready;
    assign s1_free       = !r_s1_vld || o_take;
    assign s_axis_tready = s1_free;
    assign acc           = s_axis_tvalid && s_axis_tready;

    // Capacity limit, one bit wider for the compare.
    assign lim = {1'b0, r_cap};

    // Parser.
    always_comb begin
        n_phase = r_phase;
        n_mnib  = r_mnib;
        n_lit   = r_lit;
        n_mlen  = r_mlen;
        n_off   = r_off;
        n_prod  = r_prod;
        n_skip  = r_skip;
        n_emit  = 1'b0;
        n_res   = '0;
        re      = 1'b0;
        rd_dist = r_off;
        mstart  = 1'b0;
        start_len = '0;
        lit_sum   = {1'b0, r_lit} + {{(CountBits-7){1'b0}}, s_axis_tdata};
        if (lit_sum > CountMax) lit_sum = CountMax;
        mlen_sum  = {1'b0, r_mlen} + {{(CountBits-7){1'b0}}, s_axis_tdata};
        if (mlen_sum > CountMax) mlen_sum = CountMax;
        mlen_len  = mlen_sum + (CountBits+1)'(4);
        if (mlen_len > CountMax) mlen_len = CountMax;
        off_full  = {1'b0, s_axis_tdata, r_off[7:0]};
        len_less  = '0;
        cap_need  = '0;
        if (acc) begin
            if (r_skip) begin
                if (s_axis_tuser == KIND_SOURCE && s_axis_tlast) begin
                    n_skip = 1'b0;
                end
            end else if (s_axis_tuser == KIND_TICK) begin
                if (r_phase != PH_COPY || r_mlen == '0) begin
                    n_emit = 1'b1; n_res.status = ST_SEQ; n_skip = 1'b1;
                end else begin
                    n_emit = 1'b1; n_res.from_mem = 1'b1; re = 1'b1;
                    n_prod = r_prod + CountBits'(1);
                    n_mlen = r_mlen - CountBits'(1);
                    n_res.copy_pending = (n_mlen != '0);
                    if (n_mlen == '0) n_phase = PH_TOKEN;
                end
            end else begin
                unique case (r_phase)
                    PH_TOKEN: begin
                        n_mnib = s_axis_tdata[3:0];
                        if (s_axis_tdata[7:4] == 4'hF) begin
                            n_lit = CountBits'(15); n_phase = PH_LIT_EXT;
                            if (s_axis_tlast) begin
                                n_emit = 1'b1; n_res.status = ST_TRUNC;
                            end
                        end else if (s_axis_tdata[7:4] == 4'h0) begin
                            n_phase = PH_OFF_LO;
                            if (s_axis_tlast) begin
                                n_emit = 1'b1; n_res.status = ST_DONE;
                                n_res.total_length = r_prod;
                            end
                        end else begin
                            start_len = (CountBits+1)'(s_axis_tdata[7:4]);
                            n_lit = start_len[CountBits-1:0];
                            n_phase = PH_LITERALS;
                            cap_need = {1'b0, r_prod} + start_len;
                            if (s_axis_tlast) begin
                                n_emit = 1'b1; n_res.status = ST_TRUNC;
                            end else if (cap_need > lim) begin
                                n_emit = 1'b1; n_res.status = ST_CAPACITY;
                                n_skip = 1'b1;
                            end
                        end
                    end
                    PH_LIT_EXT: begin
                        n_lit = lit_sum[CountBits-1:0];
                        cap_need = {1'b0, r_prod} + lit_sum;
                        if (s_axis_tlast) begin
                            n_emit = 1'b1; n_res.status = ST_TRUNC;
                        end else if (s_axis_tdata != 8'hFF) begin
                            n_phase = PH_LITERALS;
                            if (cap_need > lim) begin
                                n_emit = 1'b1; n_res.status = ST_CAPACITY;
                                n_skip = 1'b1;
                            end
                        end
                    end
                    PH_LITERALS: begin
                        if (s_axis_tlast && r_lit != CountBits'(1)) begin
                            n_emit = 1'b1; n_res.status = ST_TRUNC;
                        end else begin
                            n_emit = 1'b1;
                            n_res.out_byte = s_axis_tdata;
                            n_prod = r_prod + CountBits'(1);
                            n_lit = r_lit - CountBits'(1);
                            if (n_lit == '0) begin
                                n_phase = PH_OFF_LO;
                                if (s_axis_tlast) begin
                                    n_res.status = ST_DONE;
                                    n_res.total_length = n_prod;
                                end
                            end
                        end
                    end
                    PH_OFF_LO: begin
                        n_off = {8'h00, s_axis_tdata};
                        n_phase = PH_OFF_HI;
                        if (s_axis_tlast) begin
                            n_emit = 1'b1; n_res.status = ST_TRUNC;
                        end
                    end
                    PH_OFF_HI: begin
                        n_off = off_full[15:0];
                        if (off_full == '0 || {8'h00, off_full} > {1'b0, r_prod}
                            || off_full > 17'(WindowBytes)) begin
                            n_emit = 1'b1; n_res.status = ST_OFFSET;
                            n_skip = !s_axis_tlast;
                        end else if (r_mnib == 4'hF) begin
                            n_mlen = CountBits'(15); n_phase = PH_MATCH_EXT;
                            if (s_axis_tlast) begin
                                n_emit = 1'b1; n_res.status = ST_TRUNC;
                            end
                        end else begin
                            mstart = 1'b1;
                            start_len = (CountBits+1)'(r_mnib) + (CountBits+1)'(4);
                        end
                        rd_dist = off_full[15:0];
                    end
                    PH_MATCH_EXT: begin
                        n_mlen = mlen_sum[CountBits-1:0];
                        if (s_axis_tlast) begin
                            n_emit = 1'b1; n_res.status = ST_TRUNC;
                        end else if (s_axis_tdata != 8'hFF) begin
                            mstart = 1'b1;
                            start_len = mlen_len;
                        end
                    end
                    PH_COPY: begin
                        n_emit = 1'b1; n_res.status = ST_SEQ;
                        n_skip = !s_axis_tlast;
                    end
                    default: begin
                        n_emit = 1'b1; n_res.status = ST_SEQ;
                        n_skip = !s_axis_tlast;
                    end
                endcase
                // Match start: capacity, truncation, then the first byte.
                if (mstart) begin
                    cap_need = {1'b0, r_prod} + start_len;
                    n_emit = 1'b1;
                    if (cap_need > lim) begin
                        n_res.status = ST_CAPACITY; n_skip = !s_axis_tlast;
                    end else if (s_axis_tlast) begin
                        n_res.status = ST_TRUNC;
                    end else begin
                        n_res.from_mem = 1'b1; re = 1'b1;
                        n_prod = r_prod + CountBits'(1);
                        len_less = start_len - (CountBits+1)'(1);
                        n_mlen = len_less[CountBits-1:0];
                        n_res.copy_pending = (n_mlen != '0);
                        n_phase = (n_mlen != '0) ? PH_COPY : PH_TOKEN;
                    end
                end
            end
            // Done and every error restart the block.
            if (n_emit && n_res.status != ST_DATA) begin
                n_phase = PH_TOKEN; n_mnib = '0; n_lit = '0; n_mlen = '0;
                n_off = '0; n_prod = '0;
                if (n_res.status == ST_TRUNC) n_skip = 1'b0;
            end
            if (r_skip && !n_skip) begin
                n_phase = PH_TOKEN; n_mnib = '0; n_lit = '0; n_mlen = '0;
                n_off = '0; n_prod = '0;
            end
        end
    end

    assign raddr = r_prod[AddrBits-1:0] - rd_dist[AddrBits-1:0];

    // The byte in stage 1 is written in the same cycle as a new read, so a read
    // of its address takes it from stage 1.
    assign s1_we = r_s1_vld && r_s1.status == ST_DATA;
    assign fwd   = s1_we && r_s1_waddr == raddr;

    // Byte of stage 1: literal, forwarded byte or memory read data.
    always_comb begin
        if (!r_s1.from_mem) begin
            s1_byte = r_s1.out_byte;
        end else if (r_s1_fwd) begin
            s1_byte = r_s1_fwd_byte;
        end else begin
            s1_byte = mem_rdata;
        end
        s1_out = r_s1;
        s1_out.out_byte = s1_byte;
    end

    lz4d_history u_hist (
        .i_clk   (i_clk),
        .i_we    (s1_we),
        .i_waddr (r_s1_waddr),
        .i_wdata (s1_byte),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (mem_rdata)
    );

    // Pipeline and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 24'd65536;
            r_phase <= PH_TOKEN; r_mnib <= '0; r_lit <= '0; r_mlen <= '0;
            r_off <= '0; r_prod <= '0; r_skip <= 1'b0;
            r_s1_vld <= 1'b0; r_o_vld <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_wdata;
            r_phase <= n_phase; r_mnib <= n_mnib; r_lit <= n_lit;
            r_mlen <= n_mlen; r_off <= n_off; r_prod <= n_prod; r_skip <= n_skip;
            // Stage 1 to output register.
            if (o_take) begin
                r_o_vld <= r_s1_vld;
                if (r_s1_vld) r_o <= s1_out;
            end
            if (s1_free) begin
                r_s1_vld <= acc && n_emit;
                r_s1 <= n_res;
                r_s1_fwd <= fwd;
                r_s1_fwd_byte <= s1_byte;
                r_s1_waddr <= r_prod[AddrBits-1:0];
            end
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = {7'h00, r_o.copy_pending, r_o.total_length, r_o.out_byte};
    assign m_axis_tuser  = r_o.status;

endmodule

FILE: src/lz4d_checker.sv
// Port checker of the LZ4 block decoder and its bind statement.
module lz4d_checker
    import lz4d_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // A stalled result item holds.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Status codes stay within range.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= ST_SEQ)
        else $error("bad status");

    // Only data items may report a pending copy.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tuser == ST_DATA)
        else $error("pending copy on non-data item");

    // Only done items carry a total length; data and error items carry none.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_DONE |-> m_axis_tdata[31:8] == '0)
        else $error("length on non-done item");

    // The padding bits of tdata stay zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:33] == '0)
        else $error("padding not zero");

endmodule

bind lz4_block_decoder_unit lz4d_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
